// ===== design/led_selector_command_builder_unit_macros.svh =====
// Assertion helpers shared by the block's RTL.
`ifndef LED_SELECTOR_COMMAND_BUILDER_UNIT_MACROS_SVH
`define LED_SELECTOR_COMMAND_BUILDER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LSCB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSCB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lscb_pkg.sv =====
`default_nettype none

package lscb_pkg;

  // Request codes
  localparam logic [1:0] REQ_EDIT  = 2'd0;
  localparam logic [1:0] REQ_FLUSH = 2'd1;
  localparam logic [1:0] REQ_FREQ  = 2'd2;
  localparam logic [1:0] REQ_DUTY  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_RED   = 2'd0;
  localparam logic [1:0] CFG_GREEN = 2'd1;
  localparam logic [1:0] CFG_BLUE  = 2'd2;

  localparam logic [6:0] RED_ADDR_RST   = 7'h62;
  localparam logic [6:0] GREEN_ADDR_RST = 7'h61;
  localparam logic [6:0] BLUE_ADDR_RST  = 7'h60;

  localparam logic [7:0] SEL_REG_ADDR   = 8'h16;
  localparam logic [7:0] PRESC_REG_BASE = 8'h02;
  localparam logic [7:0] DUTY_REG_BASE  = 8'h03;
  localparam logic [2:0] SEL_BYTE_COUNT = 3'd4;
  localparam logic [2:0] PWM_BYTE_COUNT = 3'd1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  unit_mask;
    logic [2:0]  led_mode;
    logic [15:0] led_mask;
    logic [1:0]  pwm_mask;
    logic [7:0]  duty_value;
    logic [15:0] pwm_frequency;
  } in_item_t;

  typedef struct packed {
    logic [6:0] slave_address;
    logic [7:0] register_address;
    logic [7:0] data_byte0;
    logic [7:0] data_byte1;
    logic [7:0] data_byte2;
    logic [7:0] data_byte3;
    logic [2:0] byte_count;
    logic       last_transaction;
  } out_item_t;

  // Microcode
  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_NOP,
    OP_DIV,
    OP_EDIT,
    OP_EMIT_FLUSH,
    OP_EMIT_PWM
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_ACCEPT,
    C_IS_EDIT,
    C_IS_FLUSH,
    C_IS_DUTY,
    C_MORE
  } cond_t;

  typedef logic [3:0] pc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  localparam pc_t PC_IDLE      = 4'd0;
  localparam pc_t PC_DISPATCH  = 4'd1;
  localparam pc_t PC_CHK_FLUSH = 4'd2;
  localparam pc_t PC_CHK_DUTY  = 4'd3;
  localparam pc_t PC_DIV       = 4'd4;
  localparam pc_t PC_PWM       = 4'd5;
  localparam pc_t PC_PWM_END   = 4'd6;
  localparam pc_t PC_EDIT      = 4'd7;
  localparam pc_t PC_EDIT_END  = 4'd8;
  localparam pc_t PC_FLUSH     = 4'd9;
  localparam pc_t PC_LAST      = 4'd10;

  // Divider control from the sequencer
  typedef struct packed {
    logic start;
    logic step;
  } div_ctl_t;

endpackage

`default_nettype wire

// ===== design/lscb_div.sv =====
`default_nettype none

module lscb_div import lscb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire div_ctl_t    ctl,
  input  wire logic [15:0] freq,
  output logic [7:0]       quotient,
  output logic             more
);

  localparam logic [16:0] PRESC_NUM  = 17'd81920;
  localparam logic [3:0]  OVF_STEP   = 4'd8;

  logic [3:0]  cnt_r, cnt_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [24:0] dsh_r, dsh_nxt;
  logic [7:0]  quo_r, quo_nxt;
  logic        sat_r, sat_nxt;
  logic        ge;

  assign ge = {8'd0, rem_r} >= dsh_r;

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    dsh_nxt = dsh_r;
    quo_nxt = quo_r;
    sat_nxt = sat_r;
    if (ctl.start) begin
      cnt_nxt = OVF_STEP;
      rem_nxt = PRESC_NUM - {1'b0, freq};
      dsh_nxt = {freq, 9'd0};
      quo_nxt = 8'd0;
      sat_nxt = 1'b0;
    end else if (ctl.step) begin
      cnt_nxt = cnt_r - 4'd1;
      dsh_nxt = dsh_r >> 1;
      if (cnt_r == OVF_STEP) begin
        // quotient would not fit in a byte (zero frequency lands here too)
        if (ge) begin
          sat_nxt = 1'b1;
          quo_nxt = 8'hFF;
        end
      end else if (!sat_r) begin
        if (ge) begin
          rem_nxt = rem_r - dsh_r[16:0];
        end
        quo_nxt = {quo_r[6:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
    sat_r <= sat_nxt;
  end

  assign quotient = quo_r;
  assign more     = (cnt_r != 4'd0);

endmodule

`default_nettype wire

// ===== design/led_selector_command_builder_unit.sv =====
// Builds bus write transactions for three LED driver units (red, green, blue).
// in_valid/in_ready/in_item carry one request; out_valid/out_ready/out_item
// carry the write transactions it causes, last_transaction set on the final one.
// Edit requests update the stored selector words and produce no output.
// A flush yields one 4-byte selector write per modified unit; pwm requests
// yield one 1-byte write per selected unit and channel.
// A short microprogram steps through every request, one step per cycle,
// visiting each unit (or unit/channel pair) in turn; edit, flush, duty and
// frequency requests each take their own path, a frequency request first
// running the one-bit-per-cycle prescaler divider.
// in_ready is high only while the sequencer waits for a request.
// One output register holds the pending item; when the receiver stalls the
// sequencer holds on the next emitting step until the register frees up.
// cfg_we writes a unit address immediately (expected while idle).
// Synchronous reset clears selectors and modified flags, restores the
// default addresses and empties the output register.
`default_nettype none
`include "led_selector_command_builder_unit_macros.svh"

module led_selector_command_builder_unit import lscb_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_wdata
);

  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    case (pc)
      PC_IDLE:      w = '{OP_ACCEPT,     C_NO_ACCEPT, PC_IDLE};
      PC_DISPATCH:  w = '{OP_NOP,        C_IS_EDIT,   PC_EDIT};
      PC_CHK_FLUSH: w = '{OP_NOP,        C_IS_FLUSH,  PC_FLUSH};
      PC_CHK_DUTY:  w = '{OP_NOP,        C_IS_DUTY,   PC_PWM};
      PC_DIV:       w = '{OP_DIV,        C_MORE,      PC_DIV};
      PC_PWM:       w = '{OP_EMIT_PWM,   C_MORE,      PC_PWM};
      PC_PWM_END:   w = '{OP_NOP,        C_ALWAYS,    PC_IDLE};
      PC_EDIT:      w = '{OP_EDIT,       C_MORE,      PC_EDIT};
      PC_EDIT_END:  w = '{OP_NOP,        C_ALWAYS,    PC_IDLE};
      PC_FLUSH:     w = '{OP_EMIT_FLUSH, C_MORE,      PC_FLUSH};
      PC_LAST:      w = '{OP_NOP,        C_ALWAYS,    PC_IDLE};
      default:      w = '{OP_NOP,        C_ALWAYS,    PC_IDLE};
    endcase
    return w;
  endfunction

  // value mode: 'on' where the mask bit is set, 'off' elsewhere
  function automatic logic [31:0] spread_leds(input logic [15:0] m);
    logic [31:0] w;
    w = '0;
    for (int n = 0; n < 16; n++) begin
      w[2*n] = m[n];
    end
    return w;
  endfunction

  function automatic logic [31:0] apply_mode(input logic [31:0] w_in,
                                             input logic [15:0] m,
                                             input logic [1:0]  mode);
    logic [31:0] w;
    w = w_in;
    for (int n = 0; n < 16; n++) begin
      if (m[n]) begin
        w[2*n +: 2] = mode;
      end
    end
    return w;
  endfunction

  function automatic logic [31:0] reverse_leds(input logic [31:0] w_in);
    logic [31:0] w;
    for (int n = 0; n < 16; n++) begin
      w[2*(15-n) +: 2] = w_in[2*n +: 2];
    end
    return w;
  endfunction

  pc_t         pc_r, pc_nxt;
  in_item_t    item_r;
  logic [2:0]  idx_r, idx_nxt;
  logic [31:0] sel_r [3];
  logic [2:0]  mod_r;
  logic [6:0]  addr_r [3];
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r;

  uword_t      uw;
  logic        accept;
  logic        slot_free;
  logic        more;
  logic        take;
  logic        emit;
  logic        advance;
  logic        edit_we;
  logic [1:0]  cur_unit;
  logic [5:0]  pair_sel;
  logic [31:0] sel_cur;
  logic [31:0] sel_new;
  logic [31:0] sel_rev;
  logic [7:0]  pwm_data;
  logic [7:0]  pwm_reg;
  out_item_t   emit_item;
  div_ctl_t    div_ctl;
  logic [7:0]  div_quo;
  logic        div_more;

  assign uw        = ucode(pc_r);
  assign in_ready  = (uw.op == OP_ACCEPT);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  assign div_ctl.start = accept;
  assign div_ctl.step  = (uw.op == OP_DIV);

  lscb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .freq     (in_item.pwm_frequency),
    .quotient (div_quo),
    .more     (div_more)
  );

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      pair_sel[j] = item_r.unit_mask[j/2] && item_r.pwm_mask[j%2];
    end
  end

  assign cur_unit = (uw.op == OP_EMIT_PWM) ? idx_r[2:1] : idx_r[1:0];
  assign sel_cur  = sel_r[cur_unit];
  assign sel_rev  = reverse_leds(sel_cur);
  assign sel_new  = item_r.led_mode[2] ? spread_leds(item_r.led_mask)
                  : apply_mode(sel_cur, item_r.led_mask, item_r.led_mode[1:0]);
  assign pwm_data = (item_r.req_type == REQ_FREQ) ? div_quo : item_r.duty_value;
  assign pwm_reg  = ((item_r.req_type == REQ_FREQ) ? PRESC_REG_BASE : DUTY_REG_BASE)
                  + {6'd0, idx_r[0], 1'b0};

  // Datapath control decoded from the current step
  always_comb begin
    more      = 1'b0;
    emit      = 1'b0;
    advance   = 1'b0;
    edit_we   = 1'b0;
    emit_item = '0;
    case (uw.op)
      OP_DIV: begin
        more = div_more;
      end
      OP_EDIT: begin
        edit_we = item_r.unit_mask[idx_r[1:0]];
        advance = 1'b1;
        more    = (idx_r != 3'd2);
      end
      OP_EMIT_FLUSH: begin
        emit    = mod_r[idx_r[1:0]] && slot_free;
        advance = !mod_r[idx_r[1:0]] || slot_free;
        more    = !advance || (idx_r != 3'd2);
        emit_item.slave_address    = addr_r[cur_unit];
        emit_item.register_address = SEL_REG_ADDR;
        emit_item.data_byte0       = sel_rev[7:0];
        emit_item.data_byte1       = sel_rev[15:8];
        emit_item.data_byte2       = sel_rev[23:16];
        emit_item.data_byte3       = sel_rev[31:24];
        emit_item.byte_count       = SEL_BYTE_COUNT;
        emit_item.last_transaction = !(|(mod_r & (3'b110 << idx_r[1:0])));
      end
      OP_EMIT_PWM: begin
        emit    = pair_sel[idx_r] && slot_free;
        advance = !pair_sel[idx_r] || slot_free;
        more    = !advance || (idx_r != 3'd5);
        emit_item.slave_address    = addr_r[cur_unit];
        emit_item.register_address = pwm_reg;
        emit_item.data_byte0       = pwm_data;
        emit_item.byte_count       = PWM_BYTE_COUNT;
        emit_item.last_transaction = !(|(pair_sel & (6'b111110 << idx_r)));
      end
      default: begin
        more = 1'b0;
      end
    endcase
  end

  // Sequencer: conditional jump or fall through
  always_comb begin
    case (uw.cond)
      C_ALWAYS:    take = 1'b1;
      C_NO_ACCEPT: take = !in_valid;
      C_IS_EDIT:   take = (item_r.req_type == REQ_EDIT);
      C_IS_FLUSH:  take = (item_r.req_type == REQ_FLUSH);
      C_IS_DUTY:   take = (item_r.req_type == REQ_DUTY);
      C_MORE:      take = more;
      default:     take = 1'b1;
    endcase
    pc_nxt = take ? uw.target : pc_t'(pc_r + 4'd1);
  end

  always_comb begin
    idx_nxt = idx_r;
    if (accept) begin
      idx_nxt = '0;
    end else if (advance) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      mod_r       <= '0;
      for (int u = 0; u < 3; u++) begin
        sel_r[u] <= '0;
      end
      addr_r[0] <= RED_ADDR_RST;
      addr_r[1] <= GREEN_ADDR_RST;
      addr_r[2] <= BLUE_ADDR_RST;
    end else begin
      pc_r        <= pc_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (edit_we) begin
        sel_r[cur_unit] <= sel_new;
        mod_r[cur_unit] <= 1'b1;
      end else if (emit && (uw.op == OP_EMIT_FLUSH)) begin
        mod_r[cur_unit] <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_RED:   addr_r[0] <= cfg_wdata;
          CFG_GREEN: addr_r[1] <= cfg_wdata;
          CFG_BLUE:  addr_r[2] <= cfg_wdata;
          default:   addr_r[0] <= addr_r[0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    if (emit) begin
      out_item_r <= emit_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `LSCB_ASSERT_IMP(a_emit_slot_free, clk, rst_n, emit, slot_free, "item loaded over a pending item")
  `LSCB_ASSERT_NXT(a_accept_dispatch, clk, rst_n, accept, pc_r == PC_DISPATCH, "accepted item not dispatched")
  `LSCB_ASSERT_IMP(a_pc_range, clk, rst_n, 1'b1, pc_r <= PC_LAST, "step counter beyond program")
  `LSCB_ASSERT_NXT(a_flush_clears, clk, rst_n, emit && (uw.op == OP_EMIT_FLUSH), !mod_r[$past(cur_unit)], "flushed unit still modified")

endmodule

`default_nettype wire
